### design/fddp_pkg.sv
// Package for the framed decimal distance parser.
// Holds widths, limits, register indexes and shared types; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fddp_pkg;

	localparam int BYTE_W   = 8;
	localparam int VALUE_W  = 14;
	localparam int WHOLE_W  = 10;
	localparam int TENTH_W  = 4;
	localparam int COUNT_W  = 3;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;
	localparam int TDATA_W  = 32;
	localparam int REGSEL_W = 2;

	localparam logic [COUNT_W-1:0] MAX_DIGITS = 3'd4;
	localparam logic [VALUE_W-1:0] ACC_MAX    = 14'd16383;
	localparam logic [WHOLE_W-1:0] WHOLE_MAX  = 10'd1023;

	localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'd48;
	localparam logic [BYTE_W-1:0] CHAR_NINE = 8'd57;

	localparam logic [VALUE_W-1:0] LIMIT_RESET = 14'd4000;
	localparam logic [BYTE_W-1:0]  START_RESET = 8'd64;
	localparam logic [BYTE_W-1:0]  END_RESET   = 8'd36;

	localparam logic [REGSEL_W-1:0] REG_TOO_FAR_LIMIT = 2'd0;
	localparam logic [REGSEL_W-1:0] REG_START_CHAR    = 2'd1;
	localparam logic [REGSEL_W-1:0] REG_END_CHAR      = 2'd2;

	// Reciprocal of ten, exact for values below 43690.
	localparam logic [15:0] RECIP_TEN = 16'd52429;
	localparam int          RECIP_SH  = 19;

	typedef struct packed {
		logic [VALUE_W-1:0] too_far_limit;
		logic [BYTE_W-1:0]  start_char;
		logic [BYTE_W-1:0]  end_char;
	} cfg_t;

	typedef struct packed {
		logic [TENTH_W-1:0] tenth_part;
		logic [WHOLE_W-1:0] whole_part;
		logic               too_far;
		logic [VALUE_W-1:0] distance_value;
	} result_t;

endpackage

`default_nettype wire

### design/framed_decimal_distance_parser.sv
// Top level of the framed decimal distance parser: input register, frame
// recognizer and output register. Depends on fddp_pkg, fddp_cfg_regs, fddp_frame.
//
//   Channel  Direction  Word
//   s_*      in         tdata[7:0] rx_byte
//   m_*      out        tdata[13:0] distance, [14] too_far, [24:15] whole, [28:25] tenth
//   APB      in/out     too_far_limit at 0x0, start_char at 0x4, end_char at 0x8
//
// One byte is accepted per cycle while the output is not stalled.
// The input register feeds the frame logic, which writes the output register.
// A stalled output holds its word while the input register still takes one byte.
// Reset returns the configuration registers to their defaults and the recognizer to idle.
`timescale 1ns / 1ps
`default_nettype none

module framed_decimal_distance_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,   // [7:0] rx_byte
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [13:0] distance_value, [14] too_far, [24:15] whole_part, [28:25] tenth_part
	output logic [fddp_pkg::TDATA_W-1:0]       m_tdata,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fddp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [fddp_pkg::DATA_W-1:0]   pwdata,
	output logic      [fddp_pkg::DATA_W-1:0]   prdata,
	output logic                               pready
);
	import fddp_pkg::*;

	cfg_t               cfg;
	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               advance;
	logic               emit;
	result_t            result;
	logic               out_valid_q;
	result_t            out_q;

	fddp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[BYTE_W-1:0];
		end
	end

	fddp_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.emit    (emit),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W-$bits(result_t)){1'b0}}, out_q.tenth_part, out_q.whole_part,
	                   out_q.too_far, out_q.distance_value};

endmodule

`default_nettype wire

### design/fddp_cfg_regs.sv
// Configuration register file of the framed decimal distance parser.
// APB-style write and read port; depends on fddp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fddp_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fddp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [fddp_pkg::DATA_W-1:0]   pwdata,
	output logic      [fddp_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	output fddp_pkg::cfg_t                     cfg
);
	import fddp_pkg::*;

	logic [REGSEL_W-1:0] sel;
	logic                wr_en;
	cfg_t                cfg_q;

	assign sel    = paddr[ADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.too_far_limit <= LIMIT_RESET;
			cfg_q.start_char    <= START_RESET;
			cfg_q.end_char      <= END_RESET;
		end else if (wr_en) begin
			unique case (sel)
				REG_TOO_FAR_LIMIT: cfg_q.too_far_limit <= pwdata[VALUE_W-1:0];
				REG_START_CHAR:    cfg_q.start_char    <= pwdata[BYTE_W-1:0];
				REG_END_CHAR:      cfg_q.end_char      <= pwdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_TOO_FAR_LIMIT: prdata = {{(DATA_W-VALUE_W){1'b0}}, cfg_q.too_far_limit};
			REG_START_CHAR:    prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_q.start_char};
			REG_END_CHAR:      prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_q.end_char};
			default:           prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### design/fddp_split.sv
// Splits a distance into whole and tenth parts and flags values over the limit.
// Division by ten is a reciprocal multiply; depends on fddp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fddp_split (
	input  wire logic [fddp_pkg::VALUE_W-1:0] value,
	input  wire logic [fddp_pkg::VALUE_W-1:0] too_far_limit,
	output fddp_pkg::result_t                 result
);
	import fddp_pkg::*;

	logic [VALUE_W+15:0] prod;
	logic [10:0]         quot;
	logic [VALUE_W-1:0]  times_ten;
	logic [VALUE_W-1:0]  rem;

	assign prod      = {16'd0, value} * {{VALUE_W{1'b0}}, RECIP_TEN};
	assign quot      = prod[RECIP_SH+10:RECIP_SH];
	assign times_ten = {quot[10:0], 3'b000} + {2'b00, quot[10:0], 1'b0};
	assign rem       = value - times_ten;

	always_comb begin
		result.distance_value = value;
		result.too_far        = value > too_far_limit;
		result.whole_part     = (quot > {1'b0, WHOLE_MAX}) ? WHOLE_MAX : quot[WHOLE_W-1:0];
		result.tenth_part     = rem[TENTH_W-1:0];
	end

endmodule

`default_nettype wire

### design/fddp_frame.sv
// Frame recognizer: holds the frame state and digit accumulator and decides,
// for each byte, the next state and whether a result is emitted. Uses fddp_split.
`timescale 1ns / 1ps
`default_nettype none

module fddp_frame (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic [fddp_pkg::BYTE_W-1:0]  rx_byte,
	input  wire fddp_pkg::cfg_t               cfg,
	output logic                              emit,
	output fddp_pkg::result_t                 result
);
	import fddp_pkg::*;

	logic                 in_frame_q;
	logic [COUNT_W-1:0]   digit_count_q;
	logic [VALUE_W-1:0]   acc_q;

	logic                 in_frame_d;
	logic [COUNT_W-1:0]   digit_count_d;
	logic [VALUE_W-1:0]   acc_d;

	logic                 is_digit;
	logic [COUNT_W-1:0]   count_inc;
	logic [VALUE_W+3:0]   acc_next;

	assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
	assign count_inc = digit_count_q + 3'd1;
	assign acc_next  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
	                 + {{(VALUE_W){1'b0}}, rx_byte[3:0]};

	fddp_split u_split (
		.value         (acc_q),
		.too_far_limit (cfg.too_far_limit),
		.result        (result)
	);

	always_comb begin
		in_frame_d    = in_frame_q;
		digit_count_d = digit_count_q;
		acc_d         = acc_q;
		emit          = 1'b0;
		priority if (!in_frame_q) begin
			if (rx_byte == cfg.start_char) begin
				in_frame_d    = 1'b1;
				digit_count_d = '0;
				acc_d         = '0;
			end
		end else if (rx_byte == cfg.end_char) begin
			emit          = digit_count_q != '0;
			in_frame_d    = 1'b0;
			digit_count_d = '0;
			acc_d         = '0;
		end else if (rx_byte == cfg.start_char) begin
			digit_count_d = '0;
			acc_d         = '0;
		end else if (is_digit && (count_inc <= MAX_DIGITS)) begin
			digit_count_d = count_inc;
			acc_d         = (acc_next > {4'd0, ACC_MAX}) ? ACC_MAX : acc_next[VALUE_W-1:0];
		end else begin
			in_frame_d    = 1'b0;
			digit_count_d = '0;
			acc_d         = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			digit_count_q <= '0;
			acc_q         <= '0;
		end else if (step) begin
			in_frame_q    <= in_frame_d;
			digit_count_q <= digit_count_d;
			acc_q         <= acc_d;
		end
	end

endmodule

`default_nettype wire

### design/fddp_checker.sv
// Port-level checker for the framed decimal distance parser, bound to the top level.
// Sees only the top-level ports; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module fddp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        pready
);

	// A held result word must not change until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// A fresh result must trace back to an accepted byte.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result appeared without a matching input byte");

	// Whole and tenth parts must rebuild the distance.
	a_split: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({22'd0, m_tdata[24:15]} * 32'd10 + {28'd0, m_tdata[28:25]})
		== {18'd0, m_tdata[13:0]})
		else $error("whole and tenth parts do not match the distance");

	// Four digits bound the distance, and the padding stays clear.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[13:0] <= 14'd9999) && (m_tdata[31:29] == 3'd0))
		else $error("distance out of range or padding set");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("configuration port not ready");

endmodule

bind framed_decimal_distance_parser fddp_checker u_fddp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);

`default_nettype wire
